/* src/mbc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers of the memoized binomial coefficient block.
package mbc_pkg;

   localparam int MAX_N_DEF          = 20;
   localparam int FIELD_W            = 5;
   localparam int COEF_W             = 18;
   localparam int SLOT_W             = 8;
   localparam int FIFO_DEPTH_DEF     = 4;
   localparam int DIVIDEND_W         = 24;
   localparam int DIVISOR_W          = 4;
   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_CYCLES         = DIVIDEND_W / DIV_BITS_PER_CYCLE;

   typedef struct packed {
      logic               range_error;
      logic [FIELD_W-1:0] n_value;
      logic [FIELD_W-1:0] r_value;
      logic [SLOT_W-1:0]  slot;
   } job_type;

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [COEF_W-1:0] wr_data;
   } mem_req_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_MUL,
      B_DIV,
      B_DONE
   } back_state_type;

   function automatic logic [SLOT_W-1:0] tri_slot(input logic [FIELD_W-1:0] n,
                                                  input logic [FIELD_W-1:0] r);
      logic [2*FIELD_W-1:0] prod;
      logic [2*FIELD_W-1:0] sum;
      prod = {{FIELD_W{1'b0}}, n} * ({{FIELD_W{1'b0}}, n} + {{(2*FIELD_W-1){1'b0}}, 1'b1});
      sum  = (prod >> 1) + {{FIELD_W{1'b0}}, r};
      return sum[SLOT_W-1:0];
   endfunction

endpackage

/* src/memoized_binomial_coefficient.sv */
`timescale 1ns / 1ps
// Top level: memoized n choose r with front end, job queue, back end and memo RAM.
// On a miss, each factor of the product is a multiply step followed by 4-bit divide steps
// of a restoring division; range errors, r of 0 or n and memo hits skip that loop.
// Requests are taken one per cycle until the queue fills; the back end works on one
// transaction at a time.
// Reset clears all memo valid bits at once; no clearing pass is needed.
module memoized_binomial_coefficient #(
   parameter int MAX_N      = mbc_pkg::MAX_N_DEF,
   parameter int FIFO_DEPTH = mbc_pkg::FIFO_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mbc_pkg::FIELD_W-1:0] req_n_value,
   input  logic [mbc_pkg::FIELD_W-1:0] req_r_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mbc_pkg::COEF_W-1:0]  rsp_coefficient,
   output logic                        rsp_range_error
);

   localparam int MemoDepth = (MAX_N + 1) * (MAX_N + 2) / 2;
   localparam int AddrW     = $clog2(MemoDepth);

   logic                       push_valid;
   logic                       push_ready;
   mbc_pkg::job_type           push_job;
   logic                       pop_en;
   logic                       pop_valid;
   mbc_pkg::job_type           pop_job;
   mbc_pkg::mem_req_type       mem_req;
   logic [mbc_pkg::COEF_W-1:0] ram_rd_data;

   mbc_front #(
      .MAX_N (MAX_N)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_n_value (req_n_value),
      .req_r_value (req_r_value),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_job    (push_job)
   );

   mbc_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_en     (pop_en),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   mbc_back #(
      .MAX_N (MAX_N)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_job         (pop_job),
      .pop_en          (pop_en),
      .mem_req         (mem_req),
      .ram_rd_data     (ram_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coefficient (rsp_coefficient),
      .rsp_range_error (rsp_range_error)
   );

   mbc_ram #(
      .WIDTH (mbc_pkg::COEF_W),
      .DEPTH (MemoDepth)
   ) u_memo_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr[AddrW-1:0]),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr[AddrW-1:0]),
      .rd_data (ram_rd_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_coefficient == '0)
      else $error("range error response carries a nonzero coefficient");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_error |-> rsp_coefficient != '0)
      else $error("valid response carries a zero coefficient");

   assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> mem_req.wr_data != '0 && !mem_req.rd_en)
      else $error("memo write with zero data or colliding read");

   assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |=> !mem_req.rd_en && !mem_req.wr_en)
      else $error("memo access issued while a lookup is in flight");

endmodule

/* src/mbc_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mbc_front.sv */
`timescale 1ns / 1ps
// Front end: takes request transactions, classifies them and computes the memo slot.
module mbc_front #(
   parameter int MAX_N = mbc_pkg::MAX_N_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mbc_pkg::FIELD_W-1:0] req_n_value,
   input  logic [mbc_pkg::FIELD_W-1:0] req_r_value,
   output logic                        push_valid,
   input  logic                        push_ready,
   output mbc_pkg::job_type            push_job
);

   logic             hold_valid_ff;
   logic             hold_valid_in;
   mbc_pkg::job_type hold_job_ff;
   mbc_pkg::job_type hold_job_in;

   assign req_stall = hold_valid_ff && !push_ready;

   always_comb begin
      hold_job_in.range_error = (req_n_value > mbc_pkg::FIELD_W'(MAX_N)) ||
                                (req_r_value > req_n_value);
      hold_job_in.n_value     = req_n_value;
      hold_job_in.r_value     = req_r_value;
      hold_job_in.slot        = mbc_pkg::tri_slot(req_n_value, req_r_value);
      hold_valid_in           = req_stall ? hold_valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         hold_job_ff <= hold_job_in;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_job   = hold_job_ff;

endmodule

/* src/mbc_fifo.sv */
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
module mbc_fifo #(
   parameter int DEPTH = mbc_pkg::FIFO_DEPTH_DEF,
   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CntW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  mbc_pkg::job_type push_job,
   input  logic             pop_en,
   output logic             pop_valid,
   output mbc_pkg::job_type pop_job
);

   mbc_pkg::job_type entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff;
   logic [PtrW-1:0]  rd_ptr_ff;
   logic [CntW-1:0]  count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CntW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_en && pop_valid;
   assign pop_job    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* src/mbc_back.sv */
`timescale 1ns / 1ps
// Back end: memo lookup, multiply-divide sequencer on a miss, and the result register.
module mbc_back #(
   parameter int MAX_N = mbc_pkg::MAX_N_DEF,
   localparam int MemoDepth = (MAX_N + 1) * (MAX_N + 2) / 2,
   localparam int AddrW = $clog2(MemoDepth),
   localparam int CntW = (mbc_pkg::DIV_CYCLES > 1) ? $clog2(mbc_pkg::DIV_CYCLES) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   input  mbc_pkg::job_type           pop_job,
   output logic                       pop_en,
   output mbc_pkg::mem_req_type       mem_req,
   input  logic [mbc_pkg::COEF_W-1:0] ram_rd_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [mbc_pkg::COEF_W-1:0] rsp_coefficient,
   output logic                       rsp_range_error
);

   mbc_pkg::back_state_type state_ff;
   mbc_pkg::back_state_type state_in;

   logic [MemoDepth-1:0]                memo_valid_ff;
   mbc_pkg::job_type                    job_ff;
   logic                                miss_ff;
   logic [mbc_pkg::FIELD_W-1:0]         rr_ff;
   logic [mbc_pkg::FIELD_W-1:0]         k_ff;
   logic [mbc_pkg::COEF_W-1:0]          acc_ff;
   logic [mbc_pkg::COEF_W-1:0]          coef_ff;
   logic [mbc_pkg::DIVIDEND_W-1:0]      quo_ff;
   logic [mbc_pkg::DIVISOR_W-1:0]       rem_ff;
   logic [mbc_pkg::DIVISOR_W-1:0]       divisor_ff;
   logic [CntW-1:0]                     cnt_ff;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [mbc_pkg::COEF_W-1:0]          rsp_coef_ff;
   logic                                rsp_err_ff;

   logic                                head_hit;
   logic [mbc_pkg::FIELD_W-1:0]         head_n_minus_r;
   logic [mbc_pkg::FIELD_W-1:0]         head_rr;
   logic [mbc_pkg::FIELD_W-1:0]         n_minus_k;
   logic [mbc_pkg::DIVIDEND_W-1:0]      prod;
   logic [mbc_pkg::DIVIDEND_W-1:0]      div_q;
   logic [mbc_pkg::DIVISOR_W-1:0]       div_r;
   logic [mbc_pkg::DIVISOR_W:0]         div_part;
   logic                                div_last;
   logic                                step_last;
   logic                                out_free;
   logic                                out_load;

   assign head_hit       = memo_valid_ff[pop_job.slot[AddrW-1:0]];
   assign head_n_minus_r = pop_job.n_value - pop_job.r_value;
   assign head_rr        = (pop_job.r_value > head_n_minus_r) ? head_n_minus_r : pop_job.r_value;
   assign n_minus_k      = job_ff.n_value - k_ff;
   assign prod           = mbc_pkg::DIVIDEND_W'(acc_ff) * mbc_pkg::DIVIDEND_W'(n_minus_k);
   assign div_last       = (cnt_ff == CntW'(mbc_pkg::DIV_CYCLES - 1));
   assign step_last      = ((k_ff + 1'b1) == rr_ff);
   assign out_free       = !rsp_valid_ff || !rsp_stall;

   // restoring division, several quotient bits per cycle
   always_comb begin
      div_q = quo_ff;
      div_r = rem_ff;
      div_part = '0;
      for (int i = 0; i < mbc_pkg::DIV_BITS_PER_CYCLE; i++) begin
         div_part = {div_r, div_q[mbc_pkg::DIVIDEND_W-1]};
         div_q    = div_q << 1;
         if (div_part >= {1'b0, divisor_ff}) begin
            div_r    = mbc_pkg::DIVISOR_W'(div_part - {1'b0, divisor_ff});
            div_q[0] = 1'b1;
         end else begin
            div_r    = div_part[mbc_pkg::DIVISOR_W-1:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbc_pkg::B_IDLE: begin
            if (pop_valid) begin
               priority if (pop_job.range_error) begin
                  state_in = mbc_pkg::B_DONE;
               end else if (head_hit) begin
                  state_in = mbc_pkg::B_READ;
               end else if (head_rr == '0) begin
                  state_in = mbc_pkg::B_DONE;
               end else begin
                  state_in = mbc_pkg::B_MUL;
               end
            end
         end
         mbc_pkg::B_READ: state_in = mbc_pkg::B_DONE;
         mbc_pkg::B_MUL:  state_in = mbc_pkg::B_DIV;
         mbc_pkg::B_DIV: begin
            if (div_last) begin
               state_in = step_last ? mbc_pkg::B_DONE : mbc_pkg::B_MUL;
            end
         end
         mbc_pkg::B_DONE: begin
            if (out_free) begin
               state_in = mbc_pkg::B_IDLE;
            end
         end
         default: state_in = mbc_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop_en          = (state_ff == mbc_pkg::B_IDLE) && pop_valid;
      out_load        = (state_ff == mbc_pkg::B_DONE) && out_free;
      mem_req.rd_en   = pop_en && !pop_job.range_error && head_hit;
      mem_req.rd_addr = pop_job.slot;
      mem_req.wr_en   = out_load && miss_ff;
      mem_req.wr_addr = job_ff.slot;
      mem_req.wr_data = coef_ff;
      rsp_valid_in    = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mbc_pkg::B_IDLE;
         memo_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_req.wr_en) begin
            memo_valid_ff[job_ff.slot[AddrW-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         mbc_pkg::B_IDLE: begin
            if (pop_en) begin
               job_ff  <= pop_job;
               rr_ff   <= head_rr;
               k_ff    <= '0;
               acc_ff  <= mbc_pkg::COEF_W'(1);
               coef_ff <= pop_job.range_error ? '0 : mbc_pkg::COEF_W'(1);
               miss_ff <= !pop_job.range_error && !head_hit;
            end
         end
         mbc_pkg::B_READ: coef_ff <= ram_rd_data;
         mbc_pkg::B_MUL: begin
            quo_ff     <= prod;
            rem_ff     <= '0;
            divisor_ff <= mbc_pkg::DIVISOR_W'(k_ff + 1'b1);
            cnt_ff     <= '0;
         end
         mbc_pkg::B_DIV: begin
            quo_ff <= div_q;
            rem_ff <= div_r;
            cnt_ff <= cnt_ff + 1'b1;
            if (div_last) begin
               acc_ff  <= div_q[mbc_pkg::COEF_W-1:0];
               coef_ff <= div_q[mbc_pkg::COEF_W-1:0];
               k_ff    <= k_ff + 1'b1;
            end
         end
         mbc_pkg::B_DONE: begin
            if (out_load) begin
               rsp_coef_ff <= coef_ff;
               rsp_err_ff  <= job_ff.range_error;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coef_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule
